// ===== hw/rtl/rtms_pkg.sv =====
`timescale 1ns / 1ps

package rtms_pkg;

   // command codes of an input beat
   typedef enum logic [1:0] {
      CMD_SRC_WR = 2'd0,
      CMD_TPL_WR = 2'd1,
      CMD_SEARCH = 2'd2
   } cmd_type;

   // register index, taken from paddr[4:2]
   localparam logic [2:0] CSR_MAX_DIFF   = 3'd0;
   localparam logic [2:0] CSR_SRC_WIDTH  = 3'd1;
   localparam logic [2:0] CSR_SRC_HEIGHT = 3'd2;
   localparam logic [2:0] CSR_TPL_WIDTH  = 3'd3;
   localparam logic [2:0] CSR_TPL_HEIGHT = 3'd4;

   localparam int CSR_ADDR_W = 5;
   localparam int CHANNELS   = 3;

   // pixel as stored: red in the top byte, blue in the low byte
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pix_type;

endpackage

// ===== hw/rtl/rtms_req_if.sv =====
`timescale 1ns / 1ps

interface rtms_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] col;
   logic [7:0] row;
   logic [7:0] blue;
   logic [7:0] green;
   logic [7:0] red;

   modport source (output valid, command, col, row, blue, green, red, input ready);
   modport sink   (input valid, command, col, row, blue, green, red, output ready);
endinterface

// ===== hw/rtl/rtms_rsp_if.sv =====
`timescale 1ns / 1ps

interface rtms_rsp_if;
   logic       valid;
   logic       ready;
   logic       found;
   logic [7:0] match_x;
   logic [7:0] match_y;

   modport source (output valid, found, match_x, match_y, input ready);
   modport sink   (input valid, found, match_x, match_y, output ready);
endinterface

// ===== hw/rtl/rtms_ram.sv =====
`timescale 1ns / 1ps

module rtms_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/rtms_pix_cmp.sv =====
`timescale 1ns / 1ps

module rtms_pix_cmp (
   input  rtms_pkg::pix_type src_pix,
   input  rtms_pkg::pix_type tpl_pix,
   input  logic [7:0]        max_diff,
   output logic              pix_ok
);
   import rtms_pkg::*;

   logic [CHANNELS-1:0][7:0] a_ch;
   logic [CHANNELS-1:0][7:0] b_ch;
   logic [CHANNELS-1:0]      ch_ok;

   assign a_ch = src_pix;
   assign b_ch = tpl_pix;

   // per channel |a - b| <= max_diff
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         if (a_ch[c] > b_ch[c]) begin
            ch_ok[c] = (a_ch[c] - b_ch[c]) <= max_diff;
         end else begin
            ch_ok[c] = (b_ch[c] - a_ch[c]) <= max_diff;
         end
      end
   end

   assign pix_ok = &ch_ok;

endmodule

// ===== hw/rtl/rgb_template_match_search.sv =====
`timescale 1ns / 1ps
// Pixel write beats (source or template) are taken one per cycle while idle; no response.
// Search steps: start, P address/compare pairs, then done, which loads the response regs;
// P = template pixels compared; worst case P = (sw-tw+1)*(sh-th+1)*tw*th.
// Per pixel: one registered read per image RAM, then the single compare unit.
// No request is taken while a search runs; one response may wait in rsp regs, and a later
// search then holds in done until it drains. Reset: synchronous, active high; clears
// sequencer, response valid and CSRs; image RAMs are not cleared.

module rgb_template_match_search #(
   parameter int MAX_SRC_W = 256,
   parameter int MAX_SRC_H = 256,
   parameter int MAX_TPL_W = 32,
   parameter int MAX_TPL_H = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   rtms_req_if.sink                        req_chan,
   rtms_rsp_if.source                      rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [rtms_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import rtms_pkg::*;

   // ---------------------------------------------------------------- widths
   localparam int SW_BITS = $clog2(MAX_SRC_W + 1);   // holds sizes 0..MAX
   localparam int SH_BITS = $clog2(MAX_SRC_H + 1);
   localparam int TW_BITS = $clog2(MAX_TPL_W + 1);
   localparam int TH_BITS = $clog2(MAX_TPL_H + 1);
   localparam int SXW     = $clog2(MAX_SRC_W);       // source column index
   localparam int SYW     = $clog2(MAX_SRC_H);
   localparam int TXW     = (MAX_TPL_W > 1) ? $clog2(MAX_TPL_W) : 1;
   localparam int TYW     = (MAX_TPL_H > 1) ? $clog2(MAX_TPL_H) : 1;
   localparam int SDEPTH  = MAX_SRC_W * MAX_SRC_H;
   localparam int TDEPTH  = MAX_TPL_W * MAX_TPL_H;
   localparam int SAW     = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
   localparam int TAW     = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;

   // ------------------------------------------------------------ sequencer
   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_START = 5'b00010,   // clamp sizes, reject impossible searches
      S_READ  = 5'b00100,   // RAM address cycle
      S_CMP   = 5'b01000,   // compare data, step counters
      S_DONE  = 5'b10000    // park result until rsp regs free
   } state_type;

   state_type      state_ff, state_in;
   logic [SXW-1:0] ox_ff, ox_in, ox_max_ff, ox_max_in;
   logic [SYW-1:0] oy_ff, oy_in, oy_max_ff, oy_max_in;
   logic [TXW-1:0] tx_ff, tx_in;
   logic [TYW-1:0] ty_ff, ty_in;
   logic           found_ff, found_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_found_ff, rsp_found_in;
   logic [7:0]     rsp_x_ff, rsp_x_in;
   logic [7:0]     rsp_y_ff, rsp_y_in;

   // ------------------------------------------------------------------ CSRs
   logic [7:0] max_diff_ff;
   logic [8:0] src_width_ff, src_height_ff;
   logic [5:0] tpl_width_ff, tpl_height_ff;
   logic       csr_wr;
   logic [2:0] csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         max_diff_ff   <= 8'd0;
         src_width_ff  <= 9'd256;
         src_height_ff <= 9'd256;
         tpl_width_ff  <= 6'd32;
         tpl_height_ff <= 6'd32;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_MAX_DIFF:   max_diff_ff   <= pwdata[7:0];
            CSR_SRC_WIDTH:  src_width_ff  <= pwdata[8:0];
            CSR_SRC_HEIGHT: src_height_ff <= pwdata[8:0];
            CSR_TPL_WIDTH:  tpl_width_ff  <= pwdata[5:0];
            CSR_TPL_HEIGHT: tpl_height_ff <= pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_MAX_DIFF:   prdata = 32'(max_diff_ff);
         CSR_SRC_WIDTH:  prdata = 32'(src_width_ff);
         CSR_SRC_HEIGHT: prdata = 32'(src_height_ff);
         CSR_TPL_WIDTH:  prdata = 32'(tpl_width_ff);
         CSR_TPL_HEIGHT: prdata = 32'(tpl_height_ff);
         default:        prdata = 32'd0;
      endcase
   end

   // sizes above the store are taken as the store size
   logic [SW_BITS-1:0] sw_c;
   logic [SH_BITS-1:0] sh_c;
   logic [TW_BITS-1:0] tw_c;
   logic [TH_BITS-1:0] th_c;

   assign sw_c = SW_BITS'((32'(src_width_ff) > 32'(MAX_SRC_W)) ?
                          32'(MAX_SRC_W) : 32'(src_width_ff));
   assign sh_c = SH_BITS'((32'(src_height_ff) > 32'(MAX_SRC_H)) ?
                          32'(MAX_SRC_H) : 32'(src_height_ff));
   assign tw_c = TW_BITS'((32'(tpl_width_ff) > 32'(MAX_TPL_W)) ?
                          32'(MAX_TPL_W) : 32'(tpl_width_ff));
   assign th_c = TH_BITS'((32'(tpl_height_ff) > 32'(MAX_TPL_H)) ?
                          32'(MAX_TPL_H) : 32'(tpl_height_ff));

   logic size_bad;
   assign size_bad = (sw_c == '0) || (sh_c == '0) || (tw_c == '0) || (th_c == '0) ||
                     (32'(tw_c) > 32'(sw_c)) || (32'(th_c) > 32'(sh_c));

   // --------------------------------------------------------- request side
   logic req_acc;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_acc        = req_chan.valid && req_chan.ready;

   logic src_in_range, tpl_in_range;
   assign src_in_range = (32'(req_chan.col) < 32'(MAX_SRC_W)) &&
                         (32'(req_chan.row) < 32'(MAX_SRC_H));
   assign tpl_in_range = (32'(req_chan.col) < 32'(MAX_TPL_W)) &&
                         (32'(req_chan.row) < 32'(MAX_TPL_H));

   // -------------------------------------------------------- address unit
   // shared by write beats (idle) and search reads (busy)
   logic [SXW-1:0] sx;
   logic [SYW-1:0] sy;
   logic [31:0]    a_scol, a_srow, a_tcol, a_trow;
   logic [SAW-1:0] src_addr;
   logic [TAW-1:0] tpl_addr;

   assign sx = SXW'(32'(ox_ff) + 32'(tx_ff));
   assign sy = SYW'(32'(oy_ff) + 32'(ty_ff));

   always_comb begin
      if (state_ff == S_IDLE) begin
         a_scol = 32'(req_chan.col);
         a_srow = 32'(req_chan.row);
         a_tcol = 32'(req_chan.col);
         a_trow = 32'(req_chan.row);
      end else begin
         a_scol = 32'(sx);
         a_srow = 32'(sy);
         a_tcol = 32'(tx_ff);
         a_trow = 32'(ty_ff);
      end
   end

   assign src_addr = SAW'(a_srow * 32'(MAX_SRC_W) + a_scol);
   assign tpl_addr = TAW'(a_trow * 32'(MAX_TPL_W) + a_tcol);

   pix_type req_pix;
   assign req_pix = '{red: req_chan.red, green: req_chan.green, blue: req_chan.blue};

   logic    src_we, tpl_we;
   pix_type src_rd, tpl_rd;
   assign src_we = req_acc && (req_chan.command == CMD_SRC_WR) && src_in_range;
   assign tpl_we = req_acc && (req_chan.command == CMD_TPL_WR) && tpl_in_range;

   rtms_ram #(.WIDTH($bits(pix_type)), .DEPTH(SDEPTH)) u_src_ram (
      .clock   (clock),
      .wr_en   (src_we),
      .wr_addr (src_addr),
      .wr_data (req_pix),
      .rd_addr (src_addr),
      .rd_data (src_rd)
   );

   rtms_ram #(.WIDTH($bits(pix_type)), .DEPTH(TDEPTH)) u_tpl_ram (
      .clock   (clock),
      .wr_en   (tpl_we),
      .wr_addr (tpl_addr),
      .wr_data (req_pix),
      .rd_addr (tpl_addr),
      .rd_data (tpl_rd)
   );

   // the one compare unit
   logic pix_ok;
   rtms_pix_cmp u_cmp (
      .src_pix  (src_rd),
      .tpl_pix  (tpl_rd),
      .max_diff (max_diff_ff),
      .pix_ok   (pix_ok)
   );

   // end-of-range flags
   logic tx_last, ty_last, ox_last, oy_last;
   assign tx_last = (32'(tx_ff) == 32'(tw_c) - 32'd1);
   assign ty_last = (32'(ty_ff) == 32'(th_c) - 32'd1);
   assign ox_last = (ox_ff == ox_max_ff);
   assign oy_last = (oy_ff == oy_max_ff);

   // ------------------------------------------------------ next state
   always_comb begin
      state_in     = state_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      ox_max_in    = ox_max_ff;
      oy_max_in    = oy_max_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_found_in = rsp_found_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_acc && (req_chan.command == CMD_SEARCH)) begin
               state_in = S_START;
            end
         end
         S_START: begin
            ox_in = '0;
            oy_in = '0;
            tx_in = '0;
            ty_in = '0;
            ox_max_in = SXW'(32'(sw_c) - 32'(tw_c));
            oy_max_in = SYW'(32'(sh_c) - 32'(th_c));
            if (size_bad) begin
               found_in = 1'b0;
               state_in = S_DONE;
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            state_in = S_READ;
            if (pix_ok) begin
               // next template pixel, or the whole template matched
               if (tx_last) begin
                  tx_in = '0;
                  if (ty_last) begin
                     found_in = 1'b1;
                     state_in = S_DONE;
                  end else begin
                     ty_in = ty_ff + TYW'(1);
                  end
               end else begin
                  tx_in = tx_ff + TXW'(1);
               end
            end else begin
               // early exit: next offset in raster order
               tx_in = '0;
               ty_in = '0;
               if (ox_last) begin
                  if (oy_last) begin
                     found_in = 1'b0;
                     state_in = S_DONE;
                  end else begin
                     ox_in = '0;
                     oy_in = oy_ff + SYW'(1);
                  end
               end else begin
                  ox_in = ox_ff + SXW'(1);
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_x_in     = found_ff ? 8'(ox_ff) : 8'd0;
               rsp_y_in     = found_ff ? 8'(oy_ff) : 8'd0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath regs, no reset
   always_ff @(posedge clock) begin
      ox_ff        <= ox_in;
      oy_ff        <= oy_in;
      tx_ff        <= tx_in;
      ty_ff        <= ty_in;
      ox_max_ff    <= ox_max_in;
      oy_max_ff    <= oy_max_in;
      found_ff     <= found_in;
      rsp_found_ff <= rsp_found_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.found   = rsp_found_ff;
   assign rsp_chan.match_x = rsp_x_ff;
   assign rsp_chan.match_y = rsp_y_ff;

   // ---------------------------------------------------------- assertions
`ifndef ASSERT_OFF
   // template counters stay inside the template during compares
   a_tpl_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> ((32'(tx_ff) < 32'(tw_c)) && (32'(ty_ff) < 32'(th_c))))
      else $error("template counter out of range");

   // offsets never pass the last valid offset
   a_ofs_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> ((ox_ff <= ox_max_ff) && (oy_ff <= oy_max_ff)))
      else $error("search offset out of range");

   // a new response beat only comes from the done state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response beat without finished search");
`endif

endmodule
